// ===== hdl/dllm_pkg.sv =====
package dllm_pkg;

    // Fixed field widths of the item channels
    localparam int ACTION_W = 3;
    localparam int ENTRY_W  = 4;

    // Action codes carried by an input item
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_REMOVE     = 3'd4
    } t_action;

    // One result item
    typedef struct packed {
        logic [ENTRY_W-1:0] popped_entry;
        logic               popped_valid;
        logic               error_flag;
        logic               list_empty;
    } t_result;

endpackage

// ===== hdl/dllm_if.sv =====
interface dllm_in_if
    import dllm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [ENTRY_W-1:0]  entry_index;

    modport source (output valid, output action, output entry_index, input ready);
    modport sink   (input valid, input action, input entry_index, output ready);
endinterface

interface dllm_out_if
    import dllm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ENTRY_W-1:0] popped_entry;
    logic               popped_valid;
    logic               error_flag;
    logic               list_empty;

    modport source (output valid, output popped_entry, output popped_valid,
                     output error_flag, output list_empty, input ready);
    modport sink   (input valid, input popped_entry, input popped_valid,
                     input error_flag, input list_empty, output ready);
endinterface

// ===== hdl/dllm_list_core.sv =====
module dllm_list_core
    import dllm_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [ENTRY_W-1:0]  i_entry,
    output t_result             o_res
);

    localparam int IW = $clog2(SLOT_COUNT + 1);
    localparam logic [IW-1:0] HEAD = IW'(SLOT_COUNT);

    // Link arrays (head sentinel at index SLOT_COUNT) and membership bits
    logic [IW-1:0] r_next [SLOT_COUNT+1];
    logic [IW-1:0] r_prev [SLOT_COUNT+1];
    logic          r_member [SLOT_COUNT];

    // Two write ports per link array; addresses never collide within one item
    logic          nx_we0, nx_we1, pv_we0, pv_we1;
    logic [IW-1:0] nx_wa0, nx_wa1, pv_wa0, pv_wa1;
    logic [IW-1:0] nx_wd0, nx_wd1, pv_wd0, pv_wd1;
    logic          mem_we, mem_wd;
    logic [IW-1:0] mem_wa;

    logic [IW-1:0] e_idx, head_n, head_p, sel, sel_n, sel_p, new_head_n;
    logic          in_pool, is_member, empty_now;

    assign e_idx     = IW'(i_entry);
    assign in_pool   = 32'(i_entry) < 32'(SLOT_COUNT);
    assign is_member = in_pool && r_member[e_idx[$clog2(SLOT_COUNT)-1:0]];
    assign head_n    = r_next[HEAD];
    assign head_p    = r_prev[HEAD];
    assign empty_now = (head_n == HEAD);

    // Neighbors of the slot a pop or remove takes out
    always_comb begin
        unique case (i_action)
            ACT_POP_FRONT: sel = head_n;
            ACT_POP_BACK:  sel = head_p;
            default:       sel = e_idx;
        endcase
    end
    assign sel_n = r_next[sel];
    assign sel_p = r_prev[sel];

    // Decode the action into link writes and a result
    always_comb begin
        nx_we0 = 1'b0; nx_wa0 = HEAD; nx_wd0 = HEAD;
        nx_we1 = 1'b0; nx_wa1 = HEAD; nx_wd1 = HEAD;
        pv_we0 = 1'b0; pv_wa0 = HEAD; pv_wd0 = HEAD;
        pv_we1 = 1'b0; pv_wa1 = HEAD; pv_wd1 = HEAD;
        mem_we = 1'b0; mem_wa = e_idx; mem_wd = 1'b0;
        o_res  = '0;
        unique case (i_action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (!in_pool || is_member) begin
                    o_res.error_flag = 1'b1;
                end else begin
                    // attach e between p and n
                    nx_we0 = 1'b1; nx_wa0 = e_idx;
                    pv_we0 = 1'b1; pv_wa0 = e_idx;
                    nx_we1 = 1'b1; nx_wd1 = e_idx;
                    pv_we1 = 1'b1; pv_wd1 = e_idx;
                    if (i_action == ACT_PUSH_FRONT) begin
                        nx_wd0 = head_n; pv_wd0 = HEAD;
                        pv_wa1 = head_n; nx_wa1 = HEAD;
                    end else begin
                        nx_wd0 = HEAD;   pv_wd0 = head_p;
                        pv_wa1 = HEAD;   nx_wa1 = head_p;
                    end
                    mem_we = 1'b1; mem_wd = 1'b1;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK, ACT_REMOVE: begin
                if ((i_action == ACT_REMOVE) ? !is_member : empty_now) begin
                    o_res.error_flag = 1'b1;
                end else begin
                    // detach sel
                    pv_we0 = 1'b1; pv_wa0 = sel_n; pv_wd0 = sel_p;
                    nx_we0 = 1'b1; nx_wa0 = sel_p; nx_wd0 = sel_n;
                    mem_we = 1'b1; mem_wa = sel; mem_wd = 1'b0;
                    if (i_action != ACT_REMOVE) begin
                        o_res.popped_entry = ENTRY_W'(sel);
                        o_res.popped_valid = 1'b1;
                    end
                end
            end
            default: o_res.error_flag = 1'b1;
        endcase
        // head's forward link after this item
        new_head_n = head_n;
        if (nx_we0 && nx_wa0 == HEAD) new_head_n = nx_wd0;
        if (nx_we1 && nx_wa1 == HEAD) new_head_n = nx_wd1;
        o_res.list_empty = (new_head_n == HEAD);
    end

    // State update on a committed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= SLOT_COUNT; i++) begin
                r_next[i] <= HEAD;
                r_prev[i] <= HEAD;
            end
            for (int i = 0; i < SLOT_COUNT; i++) r_member[i] <= 1'b0;
        end else if (i_fire) begin
            if (nx_we0) r_next[nx_wa0] <= nx_wd0;
            if (nx_we1) r_next[nx_wa1] <= nx_wd1;
            if (pv_we0) r_prev[pv_wa0] <= pv_wd0;
            if (pv_we1) r_prev[pv_wa1] <= pv_wd1;
            if (mem_we) r_member[mem_wa[$clog2(SLOT_COUNT)-1:0]] <= mem_wd;
        end
    end

endmodule

// ===== hdl/doubly_linked_list_manager.sv =====
// Doubly linked list manager: a circular list over a pool of entry slots.
// i_item (sink): action (push front/back, pop front/back, remove) and an
//   entry index; an item is taken at an edge with valid and ready high.
// o_result (source): popped entry, popped valid, error flag and whether the
//   list is empty after the item; exactly one result per input item.
// Path: an accepted item is captured in the input register, then applied to
//   the link state and its result registered when the execute stage moves.
// Throughput: one item per cycle while results are taken; each item reads and
//   rewrites the neighbor links held in flops within the execute stage.
// Stall: while a result waits, one more item may enter the input register;
//   ready then drops until the result is taken. Nothing is lost or repeated.
// Reset (synchronous, active low): the list is empty, all membership bits
//   clear, both stages empty.
module doubly_linked_list_manager
    import dllm_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dllm_in_if.sink     i_item,
    dllm_out_if.source  o_result
);

    logic                r_in_valid, r_out_valid;
    logic [ACTION_W-1:0] r_in_action;
    logic [ENTRY_W-1:0]  r_in_entry;
    t_result             r_out, core_res;
    logic                advance;

    // Execute stage moves when the result register is free or being drained
    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_action <= i_item.action;
            r_in_entry  <= i_item.entry_index;
        end
    end

    dllm_list_core #(.SLOT_COUNT(SLOT_COUNT)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_action(r_in_action),
        .i_entry (r_in_entry),
        .o_res   (core_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) r_out <= core_res;
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.popped_entry = r_out.popped_entry;
    assign o_result.popped_valid = r_out.popped_valid;
    assign o_result.error_flag   = r_out.error_flag;
    assign o_result.list_empty   = r_out.list_empty;

endmodule

// ===== hdl/dllm_checker.sv =====
module dllm_checker
    import dllm_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [ENTRY_W-1:0] i_popped_entry,
    input logic               i_popped_valid,
    input logic               i_error_flag,
    input logic               i_list_empty
);

    // No result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A popped entry is never an error
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_popped_valid |-> !i_error_flag)
        else $error("pop reported with error");

    // Popped entry reads zero when nothing was popped
    a_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_popped_valid |-> i_popped_entry == '0)
        else $error("popped entry nonzero without pop");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_popped_entry)
        && $stable(i_popped_valid) && $stable(i_error_flag) && $stable(i_list_empty))
        else $error("stalled result changed");

endmodule

bind doubly_linked_list_manager dllm_checker u_dllm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_popped_entry(o_result.popped_entry),
    .i_popped_valid(o_result.popped_valid),
    .i_error_flag  (o_result.error_flag),
    .i_list_empty  (o_result.list_empty)
);

// ===== verif/doubly_linked_list_manager_tb.sv =====
`timescale 1ns / 100ps

module doubly_linked_list_manager_tb;
    import dllm_pkg::*;

    localparam int SLOT_COUNT      = 16;
    localparam int HEAD            = SLOT_COUNT;
    localparam int LINK_W          = $clog2(SLOT_COUNT + 1);
    localparam int RESET_CYCLES    = 10;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PRESSURE_ITEMS  = 50;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 10;
    localparam int NUM_DIR         = 26;

    // Action codes the block does not define
    localparam logic [ACTION_W-1:0] ACT_RSVD_5 = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RSVD_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_RSVD_7 = 3'd7;

    // Results that can be written down directly
    localparam t_result ERR_ON_EMPTY = '{popped_entry: '0, popped_valid: 1'b0,
                                         error_flag: 1'b1, list_empty: 1'b1};
    localparam t_result ERR_LISTED   = '{popped_entry: '0, popped_valid: 1'b0,
                                         error_flag: 1'b1, list_empty: 1'b0};
    localparam t_result OK_LISTED    = '{popped_entry: '0, popped_valid: 1'b0,
                                         error_flag: 1'b0, list_empty: 1'b0};

    typedef struct packed {
        logic [ACTION_W-1:0] op;
        logic [ENTRY_W-1:0]  idx;
        logic                typed;
        t_result             want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    dllm_in_if  item_if ();
    dllm_out_if res_if ();

    doubly_linked_list_manager #(
        .SLOT_COUNT(SLOT_COUNT)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if.sink),
        .o_result (res_if.source)
    );

    // Shadow of the list: links per slot, head sentinel at HEAD
    logic [LINK_W-1:0]     fwd_link [0:SLOT_COUNT];
    logic [LINK_W-1:0]     bwd_link [0:SLOT_COUNT];
    logic [SLOT_COUNT-1:0] listed;

    t_result pending_results [$];

    // Typed expectation that rides along with the item on the wire
    logic    cur_typed;
    t_result cur_typed_res;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_req;
    int  fill_target;
    int  quiet_cycles;
    int  fail_count;
    int  n_items;
    int  n_popped;
    int  n_refused;
    int  peak_fill;

    // Directed items: extremes, every action, refusals, reserved codes
    t_dir_row script [0:NUM_DIR-1] = '{
        '{ACT_POP_FRONT,  4'd0,  1'b1, ERR_ON_EMPTY},
        '{ACT_POP_BACK,   4'd15, 1'b1, ERR_ON_EMPTY},
        '{ACT_REMOVE,     4'd0,  1'b1, ERR_ON_EMPTY},
        '{ACT_RSVD_7,     4'd15, 1'b1, ERR_ON_EMPTY},
        '{ACT_PUSH_FRONT, 4'd0,  1'b1, OK_LISTED},
        '{ACT_PUSH_FRONT, 4'd0,  1'b1, ERR_LISTED},
        '{ACT_PUSH_BACK,  4'd15, 1'b1, OK_LISTED},
        '{ACT_PUSH_BACK,  4'd15, 1'b1, ERR_LISTED},
        '{ACT_PUSH_FRONT, 4'd5,  1'b0, '0},
        '{ACT_PUSH_BACK,  4'd10, 1'b0, '0},
        '{ACT_RSVD_5,     4'd3,  1'b1, ERR_LISTED},
        '{ACT_RSVD_6,     4'd12, 1'b1, ERR_LISTED},
        '{ACT_RSVD_7,     4'd0,  1'b1, ERR_LISTED},
        '{ACT_REMOVE,     4'd5,  1'b0, '0},
        '{ACT_REMOVE,     4'd5,  1'b1, ERR_LISTED},
        '{ACT_PUSH_BACK,  4'd0,  1'b1, ERR_LISTED},
        '{ACT_POP_FRONT,  4'd9,  1'b0, '0},
        '{ACT_POP_BACK,   4'd6,  1'b0, '0},
        '{ACT_POP_FRONT,  4'd15, 1'b0, '0},
        '{ACT_POP_BACK,   4'd0,  1'b1, ERR_ON_EMPTY},
        '{ACT_PUSH_BACK,  4'd7,  1'b0, '0},
        '{ACT_REMOVE,     4'd7,  1'b0, '0},
        '{ACT_PUSH_FRONT, 4'd1,  1'b0, '0},
        '{ACT_PUSH_BACK,  4'd2,  1'b0, '0},
        '{ACT_REMOVE,     4'd2,  1'b0, '0},
        '{ACT_POP_BACK,   4'd8,  1'b0, '0}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_list();
        for (int i = 0; i <= SLOT_COUNT; i++) begin
            fwd_link[i] = LINK_W'(HEAD);
            bwd_link[i] = LINK_W'(HEAD);
        end
        listed = '0;
    endfunction

    function automatic void unlink_slot(input logic [LINK_W-1:0] s);
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] n;
        p = bwd_link[s];
        n = fwd_link[s];
        bwd_link[n] = p;
        fwd_link[p] = n;
        listed[s[ENTRY_W-1:0]] = 1'b0;
    endfunction

    // Apply one action to the shadow list and return the result it gives.
    // With 4-bit indexes and 16 slots every index is inside the pool.
    function automatic t_result apply_list_op(input logic [ACTION_W-1:0] op,
                                             input logic [ENTRY_W-1:0]  idx);
        t_result           r;
        logic [LINK_W-1:0] s;
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] n;
        r = '0;
        s = LINK_W'(idx);
        case (op)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (listed[idx]) begin
                    r.error_flag = 1'b1;
                end else begin
                    if (op == ACT_PUSH_FRONT) begin
                        p = LINK_W'(HEAD);
                        n = fwd_link[HEAD];
                    end else begin
                        p = bwd_link[HEAD];
                        n = LINK_W'(HEAD);
                    end
                    fwd_link[s] = n;
                    bwd_link[s] = p;
                    bwd_link[n] = s;
                    fwd_link[p] = s;
                    listed[idx] = 1'b1;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
                if (fwd_link[HEAD] == LINK_W'(HEAD)) begin
                    r.error_flag = 1'b1;
                end else begin
                    s = (op == ACT_POP_FRONT) ? fwd_link[HEAD] : bwd_link[HEAD];
                    unlink_slot(s);
                    r.popped_entry = s[ENTRY_W-1:0];
                    r.popped_valid = 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (!listed[idx]) begin
                    r.error_flag = 1'b1;
                end else begin
                    unlink_slot(s);
                end
            end
            default: begin
                r.error_flag = 1'b1;
            end
        endcase
        r.list_empty = (fwd_link[HEAD] == LINK_W'(HEAD));
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    // Acceptance on both channels, prediction, comparison
    always @(posedge i_clk) begin : watch_channels
        t_result got;
        t_result want;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (item_if.valid && item_if.ready) begin
                moved = 1'b1;
                n_items++;
                want = apply_list_op(item_if.action, item_if.entry_index);
                if (cur_typed) begin
                    want = cur_typed_res;
                end
                pending_results.push_back(want);
                if ($countones(listed) > peak_fill) begin
                    peak_fill = $countones(listed);
                end
            end
            if (res_if.valid && res_if.ready) begin
                moved = 1'b1;
                got.popped_entry = res_if.popped_entry;
                got.popped_valid = res_if.popped_valid;
                got.error_flag   = res_if.error_flag;
                got.list_empty   = res_if.list_empty;
                if (got.popped_valid) n_popped++;
                if (got.error_flag)   n_refused++;
                if (pending_results.size() == 0) begin
                    note_failure($sformatf(
                        "result with none pending: entry=%0d pv=%0b err=%0b empty=%0b",
                        got.popped_entry, got.popped_valid, got.error_flag,
                        got.list_empty));
                end else begin
                    want = pending_results.pop_front();
                    if (got.popped_entry !== want.popped_entry
                            || got.popped_valid !== want.popped_valid
                            || got.error_flag !== want.error_flag
                            || got.list_empty !== want.list_empty) begin
                        note_failure($sformatf(
                            {"exp entry=%0d pv=%0b err=%0b empty=%0b, ",
                             "got entry=%0d pv=%0b err=%0b empty=%0b"},
                            want.popped_entry, want.popped_valid,
                            want.error_flag, want.list_empty,
                            got.popped_entry, got.popped_valid,
                            got.error_flag, got.list_empty));
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog: too long with nothing moving on either channel
    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[%0t] timeout: no item moved for %0d cycles, %0d results pending",
                 $realtime, WATCHDOG_LIMIT, pending_results.size());
        $display("** doubly_linked_list_manager: FAILED **");
        $finish;
    end

    // Result side ready: random stalls, plus one long hold on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Called at a falling edge; returns at the edge that takes the item
    task automatic drive_item(input logic [ACTION_W-1:0] op, input logic [ENTRY_W-1:0] idx,
                              input logic typed, input t_result res);
        while ($urandom_range(99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid       <= 1'b1;
        item_if.action      <= op;
        item_if.entry_index <= idx;
        cur_typed     = typed;
        cur_typed_res = res;
        do @(posedge i_clk); while (!(item_if.valid && item_if.ready));
    endtask

    // Mostly legal traffic steered toward a fill level, some noise
    task automatic pick_item(output logic [ACTION_W-1:0] op,
                             output logic [ENTRY_W-1:0] idx);
        int cnt;
        int start;
        bit grow;
        cnt   = $countones(listed);
        start = $urandom_range(SLOT_COUNT - 1);
        idx   = ENTRY_W'(start);
        if ($urandom_range(99) < 8) begin
            op = ACTION_W'($urandom_range(7));
        end else begin
            grow = (cnt < fill_target) ? ($urandom_range(99) < 80)
                                       : ($urandom_range(99) < 20);
            if (cnt == 0)          grow = 1'b1;
            if (cnt == SLOT_COUNT) grow = 1'b0;
            // first slot from a random start whose membership suits the action
            for (int k = 0; k < SLOT_COUNT; k++) begin
                if (listed[(start + k) % SLOT_COUNT] == !grow) begin
                    idx = ENTRY_W'((start + k) % SLOT_COUNT);
                    break;
                end
            end
            if (grow) begin
                op = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
            end else begin
                case ($urandom_range(2))
                    0:       op = ACT_POP_FRONT;
                    1:       op = ACT_POP_BACK;
                    default: op = ACT_REMOVE;
                endcase
            end
        end
    endtask

    // Drop valid and hold off until every pending result is back
    task automatic wait_drained();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        logic [ACTION_W-1:0] op;
        logic [ENTRY_W-1:0]  idx;
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 0) begin
                fill_target = $urandom_range(SLOT_COUNT);
            end
            @(negedge i_clk);
            pick_item(op, idx);
            drive_item(op, idx, 1'b0, '0);
        end
    endtask

    // Main sequence
    initial begin
        i_rst_n             = 1'b0;
        item_if.valid       = 1'b0;
        item_if.action      = '0;
        item_if.entry_index = '0;
        cur_typed           = 1'b0;
        cur_typed_res       = '0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        hold_req            = 1'b0;
        fill_target         = 0;
        quiet_cycles        = 0;
        fail_count          = 0;
        n_items             = 0;
        n_popped            = 0;
        n_refused           = 0;
        peak_fill           = 0;
        clear_list();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed items, no idling
        foreach (script[i]) begin
            @(negedge i_clk);
            drive_item(script[i].op, script[i].idx, script[i].typed, script[i].want);
        end
        wait_drained();

        // random items under four idle patterns
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            run_random(ITEMS_PER_PHASE);
            wait_drained();
        end

        // long output hold while items keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        run_random(PRESSURE_ITEMS);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d items (directed, four idle patterns, long output hold);",
                 n_items);
        $display("%0d entries popped, %0d items refused, list held up to %0d entries.",
                 n_popped, n_refused, peak_fill);
        if (fail_count == 0) begin
            $display("** doubly_linked_list_manager: PASSED **");
        end else begin
            $display("%0d mismatches in total", fail_count);
            $display("** doubly_linked_list_manager: FAILED **");
        end
        $finish;
    end

endmodule
